// File: rtl/core/kmpq_pkg.sv
//------------------------------------------------------------------------------
// kmpq_pkg
// Shared types, codes and default sizes of the keyed min priority queue.
//------------------------------------------------------------------------------
`default_nettype none

package kmpq_pkg;

	localparam int CAPACITY_DEF   = 64;
	localparam int MAP_SLOTS_DEF  = 128;
	localparam int KEY_BITS_DEF   = 32;
	localparam int VALUE_BITS_DEF = 32;

	localparam logic OP_ENQ = 1'b0;
	localparam logic OP_DEQ = 1'b1;

	localparam logic [2:0] STATUS_INSERTED = 3'd0;
	localparam logic [2:0] STATUS_REPLACED = 3'd1;
	localparam logic [2:0] STATUS_NO_VALUE = 3'd2;
	localparam logic [2:0] STATUS_FULL     = 3'd3;
	localparam logic [2:0] STATUS_EMPTY    = 3'd4;

	localparam logic [1:0] TAG_EMPTY   = 2'd0;
	localparam logic [1:0] TAG_USED    = 2'd1;
	localparam logic [1:0] TAG_DELETED = 2'd2;

	typedef struct packed {
		logic        op;
		logic [31:0] key;
		logic [31:0] value;
		logic [7:0]  value_len;
	} req_t;

	typedef struct packed {
		logic        ok;
		logic [2:0]  status;
		logic [31:0] out_key;
		logic [31:0] out_value;
		logic [7:0]  out_len;
		logic [6:0]  occupancy;
	} rsp_t;

	typedef enum logic [3:0] {
		S_CLEAR,
		S_IDLE,
		S_PROBE,
		S_SU,
		S_DQ_ROOT,
		S_DQ_LAST,
		S_SD_L,
		S_SD_R,
		S_PLACE,
		S_OUT
	} state_t;

endpackage

`default_nettype wire

// File: rtl/core/kmpq_ram.sv
//------------------------------------------------------------------------------
// kmpq_ram
// Generic single-write, single-read RAM with registered read data.
//------------------------------------------------------------------------------
`default_nettype none

module kmpq_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

// File: rtl/core/keyed_min_priority_queue.sv
//------------------------------------------------------------------------------
// keyed_min_priority_queue
// Binary min-heap of unique keys with value and length, plus a hashed
// key-to-slot map for finding held keys.
//
// channel  dir  handshake            payload
// req      in   req_valid/req_ready  kmpq_pkg::req_t (op, key, value, value_len)
// rsp      out  rsp_valid/rsp_ready  kmpq_pkg::rsp_t (ok, status, key, value, len, occ)
//
// One item at a time. A value-less enqueue or an empty dequeue goes straight to
// the result; replace and full take probes (one map read each); insert takes
// probes and sift-up compares; a dequeue reads the root, then if entries remain
// the last entry and children (one or two per sift-down level).
// A held result stalls the next one in S_OUT.
// After reset the map is swept to empty, with req_ready low.
// A new item is taken while the last result waits in the output register.
//------------------------------------------------------------------------------
`default_nettype none

module keyed_min_priority_queue #(
	parameter int CAPACITY   = kmpq_pkg::CAPACITY_DEF,
	parameter int MAP_SLOTS  = kmpq_pkg::MAP_SLOTS_DEF,
	parameter int KEY_BITS   = kmpq_pkg::KEY_BITS_DEF,
	parameter int VALUE_BITS = kmpq_pkg::VALUE_BITS_DEF
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            req_valid,
	output logic                 req_ready,
	input  wire kmpq_pkg::req_t  req,
	output logic                 rsp_valid,
	input  wire logic            rsp_ready,
	output kmpq_pkg::rsp_t       rsp
);

	localparam int KW  = (KEY_BITS < 32) ? KEY_BITS : 32;
	localparam int VW  = (VALUE_BITS < 32) ? VALUE_BITS : 32;
	localparam int AW  = $clog2(CAPACITY);
	localparam int CW  = $clog2(CAPACITY + 1);
	localparam int MW  = $clog2(MAP_SLOTS);
	localparam int IW  = AW + 2;
	localparam int HW  = KW + VW + 8 + MW;
	localparam int MPW = 2 + KW + AW;

	kmpq_pkg::state_t state_q, state_d;

	logic [CW-1:0] count_q, count_d;
	logic [MW-1:0] clr_q, clr_d;
	logic [KW-1:0] k_q, k_d;
	logic [VW-1:0] v_q, v_d;
	logic [7:0]    len_q, len_d;
	logic [MW-1:0] h_q, h_d;
	logic [MW-1:0] probe_q, probe_d;
	logic [MW-1:0] free_q, free_d;
	logic          free_vld_q, free_vld_d;
	logic [HW-1:0] e_q, e_d;
	logic [HW-1:0] lc_q, lc_d;
	logic [AW-1:0] i_q, i_d;
	logic          res_ok_q, res_ok_d;
	logic [2:0]    res_status_q, res_status_d;
	logic [KW-1:0] res_key_q, res_key_d;
	logic [VW-1:0] res_val_q, res_val_d;
	logic [7:0]    res_len_q, res_len_d;
	logic          rsp_valid_q;
	kmpq_pkg::rsp_t rsp_q;
	logic          rsp_load;

	logic           h_we;
	logic [AW-1:0]  h_waddr, h_raddr;
	logic [HW-1:0]  h_wdata, h_rdata;
	logic           m_we;
	logic [MW-1:0]  m_waddr, m_raddr;
	logic [MPW-1:0] m_wdata, m_rdata;

	kmpq_ram #(.WIDTH(HW), .DEPTH(CAPACITY)) u_heap (
		.clk  (clk),
		.we   (h_we),
		.waddr(h_waddr),
		.wdata(h_wdata),
		.raddr(h_raddr),
		.rdata(h_rdata)
	);

	kmpq_ram #(.WIDTH(MPW), .DEPTH(MAP_SLOTS)) u_map (
		.clk  (clk),
		.we   (m_we),
		.waddr(m_waddr),
		.wdata(m_wdata),
		.raddr(m_raddr),
		.rdata(m_rdata)
	);

	// heap word: key | value | len | map slot
	logic [KW-1:0] hr_key, e_key;
	logic [MW-1:0] hr_ms, e_ms;
	assign hr_key = h_rdata[HW-1 -: KW];
	assign hr_ms  = h_rdata[MW-1:0];
	assign e_key  = e_q[HW-1 -: KW];
	assign e_ms   = e_q[MW-1:0];

	// map word: tag | key | heap slot
	logic [1:0]    mr_tag;
	logic [KW-1:0] mr_key;
	logic [AW-1:0] mr_slot;
	assign mr_tag  = m_rdata[MPW-1 -: 2];
	assign mr_key  = m_rdata[AW+KW-1 -: KW];
	assign mr_slot = m_rdata[AW-1:0];

	// home slot of the incoming key
	logic [MW+KW-1:0] key_ext;
	logic [MW-1:0]    h_raw, home, h_next;
	assign key_ext = {{MW{1'b0}}, req.key[KW-1:0]};
	assign h_raw   = key_ext[MW-1:0];
	assign home    = ({1'b0, h_raw} >= (MW+1)'(MAP_SLOTS)) ? h_raw - MW'(MAP_SLOTS) : h_raw;
	assign h_next  = (h_q == MW'(MAP_SLOTS - 1)) ? '0 : h_q + 1'b1;

	// index arithmetic
	logic [CW-1:0] cnt_m1;
	logic [AW-1:0] ins_p, i_m1, par, par_m1, gpar;
	logic [IW-1:0] li, ri;
	assign cnt_m1 = count_q - 1'b1;
	assign ins_p  = cnt_m1[AW-1:0] >> 1;
	assign i_m1   = i_q - 1'b1;
	assign par    = i_m1 >> 1;
	assign par_m1 = par - 1'b1;
	assign gpar   = par_m1 >> 1;
	assign li     = (IW'(i_q) << 1) + IW'(1);
	assign ri     = (IW'(i_q) << 1) + IW'(2);

	// sift-down choice
	logic [HW-1:0] sd_left, sd_pick;
	logic [KW-1:0] sd_lkey, sd_best;
	logic          sd_right_ok, sel_l, sel_r;
	logic [IW-1:0] s_idx, s_li;
	assign sd_right_ok = (state_q == kmpq_pkg::S_SD_R);
	assign sd_left     = sd_right_ok ? lc_q : h_rdata;
	assign sd_lkey     = sd_left[HW-1 -: KW];
	assign sel_l       = sd_lkey < e_key;
	assign sd_best     = sel_l ? sd_lkey : e_key;
	assign sel_r       = sd_right_ok && (hr_key < sd_best);
	assign sd_pick     = sel_r ? h_rdata : sd_left;
	assign s_idx       = sel_r ? ri : li;
	assign s_li        = (s_idx << 1) + IW'(1);

	logic [MW-1:0] fslot;
	logic          f_ok;
	assign fslot = free_vld_q ? free_q : h_q;
	assign f_ok  = free_vld_q || (mr_tag != kmpq_pkg::TAG_USED);

	assign req_ready = (state_q == kmpq_pkg::S_IDLE);
	assign rsp_load  = (state_q == kmpq_pkg::S_OUT) && (!rsp_valid_q || rsp_ready);

	always_comb begin
		state_d      = state_q;
		count_d      = count_q;
		clr_d        = clr_q;
		k_d          = k_q;
		v_d          = v_q;
		len_d        = len_q;
		h_d          = h_q;
		probe_d      = probe_q;
		free_d       = free_q;
		free_vld_d   = free_vld_q;
		e_d          = e_q;
		lc_d         = lc_q;
		i_d          = i_q;
		res_ok_d     = res_ok_q;
		res_status_d = res_status_q;
		res_key_d    = res_key_q;
		res_val_d    = res_val_q;
		res_len_d    = res_len_q;
		h_we         = 1'b0;
		h_waddr      = i_q;
		h_wdata      = e_q;
		h_raddr      = '0;
		m_we         = 1'b0;
		m_waddr      = e_ms;
		m_wdata      = {kmpq_pkg::TAG_USED, e_key, i_q};
		m_raddr      = home;

		case (state_q)
			kmpq_pkg::S_CLEAR: begin
				m_we    = 1'b1;
				m_waddr = clr_q;
				m_wdata = {kmpq_pkg::TAG_EMPTY, {(KW + AW){1'b0}}};
				clr_d   = clr_q + 1'b1;
				if (clr_q == MW'(MAP_SLOTS - 1)) begin
					state_d = kmpq_pkg::S_IDLE;
				end
			end
			kmpq_pkg::S_IDLE: begin
				if (req_valid) begin
					k_d          = req.key[KW-1:0];
					v_d          = req.value[VW-1:0];
					len_d        = req.value_len;
					h_d          = home;
					probe_d      = '0;
					free_vld_d   = 1'b0;
					res_ok_d     = 1'b0;
					res_key_d    = '0;
					res_val_d    = '0;
					res_len_d    = '0;
					if (req.op == kmpq_pkg::OP_ENQ) begin
						if (req.value_len == 8'd0) begin
							res_status_d = kmpq_pkg::STATUS_NO_VALUE;
							state_d      = kmpq_pkg::S_OUT;
						end else begin
							state_d = kmpq_pkg::S_PROBE;
						end
					end else begin
						if (count_q == '0) begin
							res_status_d = kmpq_pkg::STATUS_EMPTY;
							state_d      = kmpq_pkg::S_OUT;
						end else begin
							h_raddr = '0;
							state_d = kmpq_pkg::S_DQ_ROOT;
						end
					end
				end
			end
			kmpq_pkg::S_PROBE: begin
				if (mr_tag == kmpq_pkg::TAG_USED && mr_key == k_q) begin
					h_we         = 1'b1;
					h_waddr      = mr_slot;
					h_wdata      = {k_q, v_q, len_q, h_q};
					res_ok_d     = 1'b1;
					res_status_d = kmpq_pkg::STATUS_REPLACED;
					res_key_d    = k_q;
					res_val_d    = v_q;
					res_len_d    = len_q;
					state_d      = kmpq_pkg::S_OUT;
				end else if (mr_tag == kmpq_pkg::TAG_EMPTY ||
				             probe_q == MW'(MAP_SLOTS - 1)) begin
					if (!f_ok || count_q >= CW'(CAPACITY)) begin
						res_status_d = kmpq_pkg::STATUS_FULL;
						state_d      = kmpq_pkg::S_OUT;
					end else begin
						e_d          = {k_q, v_q, len_q, fslot};
						i_d          = count_q[AW-1:0];
						count_d      = count_q + 1'b1;
						res_ok_d     = 1'b1;
						res_status_d = kmpq_pkg::STATUS_INSERTED;
						res_key_d    = k_q;
						res_val_d    = v_q;
						res_len_d    = len_q;
						if (count_q == '0) begin
							state_d = kmpq_pkg::S_PLACE;
						end else begin
							h_raddr = ins_p;
							state_d = kmpq_pkg::S_SU;
						end
					end
				end else begin
					if (mr_tag != kmpq_pkg::TAG_USED && !free_vld_q) begin
						free_d     = h_q;
						free_vld_d = 1'b1;
					end
					m_raddr = h_next;
					h_d     = h_next;
					probe_d = probe_q + 1'b1;
				end
			end
			kmpq_pkg::S_SU: begin
				h_we = 1'b1;
				m_we = 1'b1;
				if (hr_key > e_key) begin
					h_wdata = h_rdata;
					m_waddr = hr_ms;
					m_wdata = {kmpq_pkg::TAG_USED, hr_key, i_q};
					i_d     = par;
					if (par == '0) begin
						state_d = kmpq_pkg::S_PLACE;
					end else begin
						h_raddr = gpar;
					end
				end else begin
					state_d = kmpq_pkg::S_OUT;
				end
			end
			kmpq_pkg::S_DQ_ROOT: begin
				res_ok_d     = 1'b1;
				res_status_d = kmpq_pkg::STATUS_INSERTED;
				res_key_d    = hr_key;
				res_val_d    = h_rdata[HW-KW-1 -: VW];
				res_len_d    = h_rdata[MW+7 -: 8];
				m_we         = 1'b1;
				m_waddr      = hr_ms;
				m_wdata      = {kmpq_pkg::TAG_DELETED, hr_key, {AW{1'b0}}};
				count_d      = cnt_m1;
				if (count_q == CW'(1)) begin
					state_d = kmpq_pkg::S_OUT;
				end else begin
					h_raddr = cnt_m1[AW-1:0];
					state_d = kmpq_pkg::S_DQ_LAST;
				end
			end
			kmpq_pkg::S_DQ_LAST: begin
				e_d = h_rdata;
				i_d = '0;
				if (CW'(2) <= count_q) begin
					h_raddr = AW'(1);
					state_d = kmpq_pkg::S_SD_L;
				end else begin
					state_d = kmpq_pkg::S_PLACE;
				end
			end
			kmpq_pkg::S_SD_L, kmpq_pkg::S_SD_R: begin
				if (state_q == kmpq_pkg::S_SD_L && ri < IW'(count_q)) begin
					lc_d    = h_rdata;
					h_raddr = ri[AW-1:0];
					state_d = kmpq_pkg::S_SD_R;
				end else if (sel_l || sel_r) begin
					h_we    = 1'b1;
					h_wdata = sd_pick;
					m_we    = 1'b1;
					m_waddr = sd_pick[MW-1:0];
					m_wdata = {kmpq_pkg::TAG_USED, sd_pick[HW-1 -: KW], i_q};
					i_d     = s_idx[AW-1:0];
					if (s_li < IW'(count_q)) begin
						h_raddr = s_li[AW-1:0];
						state_d = kmpq_pkg::S_SD_L;
					end else begin
						state_d = kmpq_pkg::S_PLACE;
					end
				end else begin
					state_d = kmpq_pkg::S_PLACE;
				end
			end
			kmpq_pkg::S_PLACE: begin
				h_we    = 1'b1;
				m_we    = 1'b1;
				state_d = kmpq_pkg::S_OUT;
			end
			kmpq_pkg::S_OUT: begin
				if (rsp_load) begin
					state_d = kmpq_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = kmpq_pkg::S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= kmpq_pkg::S_CLEAR;
			count_q     <= '0;
			clr_q       <= '0;
			free_vld_q  <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q    <= state_d;
			count_q    <= count_d;
			clr_q      <= clr_d;
			free_vld_q <= free_vld_d;
			if (rsp_load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	logic [CW+6:0] occ_ext;
	assign occ_ext = {7'd0, count_q};

	always_ff @(posedge clk) begin
		k_q          <= k_d;
		v_q          <= v_d;
		len_q        <= len_d;
		h_q          <= h_d;
		probe_q      <= probe_d;
		free_q       <= free_d;
		e_q          <= e_d;
		lc_q         <= lc_d;
		i_q          <= i_d;
		res_ok_q     <= res_ok_d;
		res_status_q <= res_status_d;
		res_key_q    <= res_key_d;
		res_val_q    <= res_val_d;
		res_len_q    <= res_len_d;
		if (rsp_load) begin
			rsp_q.ok        <= res_ok_q;
			rsp_q.status    <= res_status_q;
			rsp_q.out_key   <= 32'(res_key_q);
			rsp_q.out_value <= 32'(res_val_q);
			rsp_q.out_len   <= res_len_q;
			rsp_q.occupancy <= occ_ext[6:0];
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(CAPACITY))
		else $error("entry count above capacity");

	a_ok_status: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (rsp.ok == (rsp.status == kmpq_pkg::STATUS_INSERTED ||
		                          rsp.status == kmpq_pkg::STATUS_REPLACED)))
		else $error("ok flag disagrees with status");

	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && !rsp.ok) |-> (rsp.out_key == '0 && rsp.out_value == '0 &&
		                            rsp.out_len == '0))
		else $error("failed item carries payload");

	a_sift_index: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == kmpq_pkg::S_SU || state_q == kmpq_pkg::S_PLACE ||
		 state_q == kmpq_pkg::S_SD_L || state_q == kmpq_pkg::S_SD_R)
		|-> (CW'(i_q) < count_q))
		else $error("sift index outside heap");

endmodule

`default_nettype wire

// File: sim/tb_keyed_min_priority_queue.sv
//------------------------------------------------------------------------------
// tb_keyed_min_priority_queue
// Drives enqueue and dequeue requests with random gaps and output stalls,
// predicts each response with a behavioral heap and scores it in order.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tb_keyed_min_priority_queue;

	localparam int CAP = kmpq_pkg::CAPACITY_DEF;

	class heap_scoreboard;
		logic [31:0] hkey [CAP];
		logic [31:0] hval [CAP];
		logic [7:0]  hlen [CAP];
		int          count;
		kmpq_pkg::rsp_t pending [$];
		int          errors;
		int          checked;

		function void clear();
			count = 0;
			pending.delete();
			errors = 0;
			checked = 0;
		endfunction

		function void swap_entries(int a, int b);
			logic [31:0] tk;
			logic [31:0] tv;
			logic [7:0]  tl;
			tk = hkey[a]; tv = hval[a]; tl = hlen[a];
			hkey[a] = hkey[b]; hval[a] = hval[b]; hlen[a] = hlen[b];
			hkey[b] = tk; hval[b] = tv; hlen[b] = tl;
		endfunction

		// The map only aids lookup; with MAP_SLOTS above CAPACITY it never fills.
		function void note_request(kmpq_pkg::req_t r);
			kmpq_pkg::rsp_t e;
			int   found;
			int   i;
			int   p;
			int   s;
			e = '0;
			found = -1;
			if (r.op == kmpq_pkg::OP_ENQ) begin
				if (r.value_len == 8'd0) begin
					e.status = kmpq_pkg::STATUS_NO_VALUE;
				end else begin
					for (i = 0; i < count; i++)
						if (hkey[i] == r.key) found = i;
					if (found >= 0) begin
						hval[found] = r.value;
						hlen[found] = r.value_len;
						e.ok = 1'b1; e.status = kmpq_pkg::STATUS_REPLACED;
					end else if (count >= CAP) begin
						e.status = kmpq_pkg::STATUS_FULL;
					end else begin
						i = count;
						hkey[i] = r.key; hval[i] = r.value; hlen[i] = r.value_len;
						count++;
						while (i > 0) begin
							p = (i - 1) / 2;
							if (hkey[p] <= hkey[i]) break;
							swap_entries(p, i);
							i = p;
						end
						e.ok = 1'b1; e.status = kmpq_pkg::STATUS_INSERTED;
					end
					if (e.ok) begin
						e.out_key = r.key; e.out_value = r.value; e.out_len = r.value_len;
					end
				end
			end else if (count == 0) begin
				e.status = kmpq_pkg::STATUS_EMPTY;
			end else begin
				e.ok = 1'b1; e.status = kmpq_pkg::STATUS_INSERTED;
				e.out_key = hkey[0]; e.out_value = hval[0]; e.out_len = hlen[0];
				count--;
				if (count > 0) begin
					hkey[0] = hkey[count]; hval[0] = hval[count]; hlen[0] = hlen[count];
					i = 0;
					forever begin
						s = i;
						if (2*i+1 < count && hkey[2*i+1] < hkey[s]) s = 2*i+1;
						if (2*i+2 < count && hkey[2*i+2] < hkey[s]) s = 2*i+2;
						if (s == i) break;
						swap_entries(s, i);
						i = s;
					end
				end
			end
			e.occupancy = 7'(count);
			pending.push_back(e);
		endfunction

		task check_response(kmpq_pkg::rsp_t got);
			kmpq_pkg::rsp_t e;
			checked++;
			if (pending.size() == 0) begin
				report_mismatch("response with none expected", '0, got.out_key);
				return;
			end
			e = pending.pop_front();
			if (got.ok !== e.ok) report_mismatch("ok", 32'(e.ok), 32'(got.ok));
			if (got.status !== e.status)
				report_mismatch("status", 32'(e.status), 32'(got.status));
			if (got.out_key !== e.out_key) report_mismatch("out_key", e.out_key, got.out_key);
			if (got.out_value !== e.out_value)
				report_mismatch("out_value", e.out_value, got.out_value);
			if (got.out_len !== e.out_len)
				report_mismatch("out_len", 32'(e.out_len), 32'(got.out_len));
			if (got.occupancy !== e.occupancy)
				report_mismatch("occupancy", 32'(e.occupancy), 32'(got.occupancy));
		endtask

		task report_mismatch(string what, logic [31:0] exp_v, logic [31:0] got_v);
			errors++;
			$display("MISMATCH item %0d %s: expected %0h got %0h", checked, what, exp_v,
				got_v);
		endtask
	endclass

	logic clk;
	logic arst_n;
	logic req_valid;
	logic req_ready;
	kmpq_pkg::req_t req;
	logic rsp_valid;
	logic rsp_ready;
	kmpq_pkg::rsp_t rsp;

	heap_scoreboard sb;
	int   sent;
	bit   hold_rsp;
	bit   sending_done;
	int   n_full, n_empty, n_repl;
	logic [31:0] keypool [16];

	keyed_min_priority_queue dut (
		.clk(clk), .arst_n(arst_n),
		.req_valid(req_valid), .req_ready(req_ready), .req(req),
		.rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp(rsp)
	);

	always #2 clk = ~clk;

	task automatic send_item(kmpq_pkg::req_t r);
		int gap;
		gap = $urandom_range(0, 7);
		if ($urandom_range(0, 3) == 0) gap = 0;
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_valid <= 1'b1;
		req <= r;
		do @(posedge clk); while (!req_ready);
		sb.note_request(r);
		sent++;
	endtask

	function automatic kmpq_pkg::req_t make_enq(logic [31:0] k, logic [31:0] v,
		logic [7:0] l);
		kmpq_pkg::req_t r;
		r.op = kmpq_pkg::OP_ENQ; r.key = k; r.value = v; r.value_len = l;
		return r;
	endfunction

	function automatic kmpq_pkg::req_t make_deq();
		kmpq_pkg::req_t r;
		r.op = kmpq_pkg::OP_DEQ; r.key = $urandom; r.value = $urandom;
		r.value_len = 8'($urandom);
		return r;
	endfunction

	function automatic logic [31:0] pick_key();
		case ($urandom_range(0, 3))
			0: return $urandom;
			1: return keypool[$urandom_range(0, 15)];
			default: return 32'($urandom_range(0, 200));
		endcase
	endfunction

	// Response side: random stalls plus a long hold-off during the fill phase.
	initial begin
		int stall;
		rsp_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_rsp) begin
				rsp_ready <= 1'b0;
				repeat (400) @(posedge clk);
				hold_rsp = 0;
			end
			stall = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 7);
			if (stall > 0) begin
				rsp_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			rsp_ready <= 1'b1;
			do @(posedge clk); while (!rsp_valid);
			sb.check_response(rsp);
			rsp_ready <= 1'b0;
		end
	end

	initial begin
		int i;
		clk = 1'b0;
		arst_n = 1'b0;
		req_valid = 1'b0;
		req = '0;
		sent = 0;
		hold_rsp = 0;
		sending_done = 0;
		sb = new();
		sb.clear();
		for (i = 0; i < 16; i++) keypool[i] = $urandom;
		keypool[0] = 32'h0; keypool[1] = 32'hFFFF_FFFF;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: empty dequeue, extremes, empty value, replace, ordering
		send_item(make_deq());
		send_item(make_enq(32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'hFF));
		send_item(make_enq(32'h0, 32'h0, 8'h01));
		send_item(make_enq(32'h5, 32'h1234_5678, 8'h00));
		send_item(make_enq(32'h0, 32'hA5A5_A5A5, 8'h80));
		send_item(make_enq(32'd128, 32'h1, 8'h2));
		send_item(make_enq(32'd256, 32'h2, 8'h3));
		send_item(make_enq(32'd127, 32'h3, 8'h4));
		for (i = 0; i < 6; i++) send_item(make_deq());
		send_item(make_enq(32'h7FFF_FFFF, 32'h5A5A_5A5A, 8'h7F));
		send_item(make_deq());

		// fill past capacity while responses are held off, then probe full
		hold_rsp = 1;
		for (i = 0; i < CAP; i++)
			send_item(make_enq($urandom, $urandom, 8'($urandom_range(1, 255))));
		send_item(make_enq($urandom, 32'h1, 8'h1));
		send_item(make_enq(sb.hkey[5], 32'hDEAD_BEEF, 8'h9));
		for (i = 0; i < CAP + 1; i++) send_item(make_deq());

		// random mix with phases biased toward growth or drain
		for (i = 0; i < 520; i++) begin
			int bias;
			bias = ((i / 60) % 2 == 0) ? 3 : 6;
			if ($urandom_range(0, 9) < bias) send_item(make_deq());
			else send_item(make_enq(pick_key(), $urandom,
				($urandom_range(0, 15) == 0) ? 8'h0 : 8'($urandom)));
		end
		req_valid <= 1'b0;
		sending_done = 1;
	end

	always @(posedge clk) begin
		if (rsp_valid && rsp_ready) begin
			if (rsp.status == kmpq_pkg::STATUS_FULL) n_full++;
			if (rsp.status == kmpq_pkg::STATUS_EMPTY) n_empty++;
			if (rsp.status == kmpq_pkg::STATUS_REPLACED) n_repl++;
		end
	end

	initial begin
		n_full = 0; n_empty = 0; n_repl = 0;
		wait (sending_done);
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (200) @(posedge clk);
		$display("Sent %0d items; %0d replaced, %0d full refusals, %0d empty dequeues.",
			sent, n_repl, n_full, n_empty);
		if (sb.errors == 0 && sb.pending.size() == 0)
			$display("tb_keyed_min_priority_queue OK");
		else
			$display("tb_keyed_min_priority_queue NOT OK");
		$finish;
	end

	initial begin
		#4ms;
		$display("Timeout with %0d responses outstanding", sb.pending.size());
		$display("tb_keyed_min_priority_queue NOT OK");
		$finish;
	end

endmodule

`default_nettype wire
